@@ design/pgs_pkg.sv @@
// ----------------------------------------------------------------------------
// pgs_pkg - pack gate sequencer shared types
// valve state codes, input kinds, display classes and the step result struct
// ----------------------------------------------------------------------------
package pgs_pkg;

    localparam int unsigned CountWidth      = 8;
    localparam logic [CountWidth-1:0] CountMax        = {CountWidth{1'b1}};
    localparam logic [CountWidth-1:0] EmptyTicksReset = CountWidth'(5);

    typedef enum logic [3:0] {
        ST_CLOSED_EMPTY       = 4'd0,
        ST_OPENED_WHILE_EMPTY = 4'd1,
        ST_CLOSED_FILLING     = 4'd2,
        ST_CLOSED_FULL        = 4'd3,
        ST_OPEN_EMPTYING      = 4'd4,
        ST_OPEN_PASS          = 4'd5,
        ST_OPEN_EMPTY         = 4'd6,
        ST_REMOVED_EARLY      = 4'd7,
        ST_CLOSED_BAD_LOT     = 4'd8,
        ST_OPEN_BAD_LOT       = 4'd9,
        ST_DUMP_CLOSED_EMPTY  = 4'd10,
        ST_DUMP_OPENED_EMPTY  = 4'd11,
        ST_DUMP_CLOSED_FILL   = 4'd12,
        ST_DUMP_PASS          = 4'd13,
        ST_DUMP_OPEN_EMPTY    = 4'd14,
        ST_DUMP_REMOVED_EARLY = 4'd15
    } valve_state_t;

    typedef enum logic [1:0] {
        KIND_TICK       = 2'd0,
        KIND_DUMP_START = 2'd1,
        KIND_DUMP_DONE  = 2'd2,
        KIND_BAD_LOT    = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        DISP_PACK_READY    = 3'd0,
        DISP_REMOVED_EARLY = 3'd1,
        DISP_DUMP_FINISHED = 3'd2,
        DISP_DUMP_REMOVED  = 3'd3,
        DISP_BAD_LOT       = 3'd4,
        DISP_DUMP_NEEDED   = 3'd5,
        DISP_NORMAL        = 3'd6
    } disp_class_t;

    // one accepted input word
    typedef struct packed {
        kind_t kind;
        logic  cut_gate_open;
        logic  end_gate_open;
    } in_word_t;

    // everything one step produces
    typedef struct packed {
        valve_state_t          state;
        disp_class_t           disp;
        logic                  done;
        logic [CountWidth-1:0] count;
    } step_t;

endpackage

@@ design/pgs_if.sv @@
// ----------------------------------------------------------------------------
// pgs_if - valid/ready channels of the pack gate sequencer
// input word channel and result word channel
// ----------------------------------------------------------------------------
interface pgs_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic       cut_gate_open;
    logic       end_gate_open;

    modport source (output valid, output kind, output cut_gate_open,
                    output end_gate_open, input ready);
    modport sink   (input valid, input kind, input cut_gate_open,
                    input end_gate_open, output ready);
endinterface

interface pgs_out_if;
    logic       valid;
    logic       ready;
    logic [3:0] valve_state;
    logic [2:0] display_class;
    logic       pack_done;

    modport source (output valid, output valve_state, output display_class,
                    output pack_done, input ready);
    modport sink   (input valid, input valve_state, input display_class,
                    input pack_done, output ready);
endinterface

@@ design/pgs_in_stage.sv @@
// ----------------------------------------------------------------------------
// pgs_in_stage - input register
// captures one input word and holds it until the step stage takes it
// ----------------------------------------------------------------------------
module pgs_in_stage (
    input  logic              clk,
    input  logic              rst_n,
    pgs_in_if.sink            in_ch,
    input  logic              take,
    output logic              word_valid,
    output pgs_pkg::in_word_t word
);
    import pgs_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_word_t word_reg;

    assign in_ch.ready = !valid_reg || take;
    assign valid_next  = (in_ch.valid && in_ch.ready) || (valid_reg && !take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            word_reg <= '{kind:          kind_t'(in_ch.kind),
                          cut_gate_open: in_ch.cut_gate_open,
                          end_gate_open: in_ch.end_gate_open};
        end
    end

    assign word_valid = valid_reg;
    assign word       = word_reg;

endmodule

@@ design/pgs_step.sv @@
// ----------------------------------------------------------------------------
// pgs_step - valve state transition
// next state, empty counter, display class and pack-done for one word
// ----------------------------------------------------------------------------
module pgs_step (
    input  pgs_pkg::valve_state_t                 mode,
    input  logic [pgs_pkg::CountWidth-1:0]        count,
    input  logic [pgs_pkg::CountWidth-1:0]        empty_ticks,
    input  pgs_pkg::in_word_t                     word,
    output pgs_pkg::step_t                        result
);
    import pgs_pkg::*;

    logic                  cut;
    logic                  end_open;
    logic [CountWidth-1:0] cnt_inc;
    valve_state_t          tick_state;
    logic [CountWidth-1:0] tick_count;
    logic                  tick_done;
    valve_state_t          new_state;
    logic [CountWidth-1:0] new_count;
    logic                  new_done;
    disp_class_t           new_disp;

    assign cut      = word.cut_gate_open;
    assign end_open = word.end_gate_open;
    assign cnt_inc  = (count == CountMax) ? count : count + CountWidth'(1);

    // later matching gate condition wins
    always_comb
    begin
        tick_state = mode;
        tick_count = cnt_inc;
        tick_done  = 1'b0;
        case (mode)
            ST_CLOSED_EMPTY:
            begin
                if (cut) tick_state = ST_CLOSED_FILLING;
                if (end_open) tick_state = ST_OPENED_WHILE_EMPTY;
            end
            ST_OPENED_WHILE_EMPTY:
            begin
                if (cut) tick_state = ST_OPEN_PASS;
                if (!end_open) tick_state = ST_REMOVED_EARLY;
            end
            ST_CLOSED_FILLING:
            begin
                if (!cut) tick_state = ST_CLOSED_FULL;
                if (end_open) tick_state = ST_OPEN_PASS;
            end
            ST_CLOSED_FULL:
            begin
                if (end_open)
                begin
                    tick_state = ST_OPEN_EMPTYING;
                    tick_count = '0;
                end
            end
            ST_OPEN_EMPTYING:
            begin
                if (cnt_inc >= empty_ticks) tick_state = ST_OPEN_EMPTY;
                if (!end_open) tick_state = ST_REMOVED_EARLY;
            end
            ST_OPEN_PASS:
            begin
                if (!cut)
                begin
                    tick_state = ST_OPEN_EMPTYING;
                    tick_count = '0;
                end
                if (!end_open) tick_state = ST_REMOVED_EARLY;
            end
            ST_OPEN_EMPTY:
            begin
                if (!end_open)
                begin
                    tick_state = ST_CLOSED_EMPTY;
                    tick_done  = 1'b1;
                end
            end
            ST_REMOVED_EARLY:
            begin
                if (end_open && cut) tick_state = ST_OPEN_PASS;
                if (end_open && !cut)
                begin
                    tick_state = ST_OPEN_EMPTYING;
                    tick_count = '0;
                end
            end
            ST_CLOSED_BAD_LOT:
            begin
                if (end_open) tick_state = ST_OPEN_BAD_LOT;
            end
            ST_OPEN_BAD_LOT:
            begin
                if (!end_open) tick_state = ST_CLOSED_EMPTY;
            end
            ST_DUMP_CLOSED_EMPTY:
            begin
                if (cut) tick_state = ST_DUMP_CLOSED_FILL;
                if (end_open) tick_state = ST_DUMP_OPENED_EMPTY;
            end
            ST_DUMP_OPENED_EMPTY:
            begin
                if (cut) tick_state = ST_DUMP_PASS;
                if (!end_open) tick_state = ST_DUMP_REMOVED_EARLY;
            end
            ST_DUMP_CLOSED_FILL:
            begin
                if (end_open) tick_state = ST_DUMP_PASS;
            end
            ST_DUMP_PASS:
            begin
                if (!end_open) tick_state = ST_DUMP_REMOVED_EARLY;
            end
            ST_DUMP_OPEN_EMPTY:
            begin
                if (!end_open) tick_state = ST_CLOSED_FILLING;
            end
            ST_DUMP_REMOVED_EARLY:
            begin
                if (end_open && !cut) tick_state = ST_DUMP_OPENED_EMPTY;
                if (end_open && cut) tick_state = ST_DUMP_PASS;
            end
            default:
            begin
                tick_state = mode;
            end
        endcase
    end

    // events force their state and leave the counter alone
    always_comb
    begin
        new_count = count;
        new_done  = 1'b0;
        case (word.kind)
            KIND_TICK:
            begin
                new_state = tick_state;
                new_count = tick_count;
                new_done  = tick_done;
            end
            KIND_DUMP_START: new_state = ST_DUMP_CLOSED_EMPTY;
            KIND_DUMP_DONE:  new_state = ST_DUMP_OPEN_EMPTY;
            KIND_BAD_LOT:    new_state = ST_CLOSED_BAD_LOT;
            default:         new_state = mode;
        endcase
    end

    always_comb
    begin
        if (new_state inside {ST_CLOSED_FULL, ST_OPEN_EMPTYING, ST_OPEN_EMPTY})
            new_disp = DISP_PACK_READY;
        else if (new_state == ST_REMOVED_EARLY)
            new_disp = DISP_REMOVED_EARLY;
        else if (new_state == ST_DUMP_OPEN_EMPTY)
            new_disp = DISP_DUMP_FINISHED;
        else if (new_state == ST_DUMP_REMOVED_EARLY)
            new_disp = DISP_DUMP_REMOVED;
        else if (new_state inside {ST_CLOSED_BAD_LOT, ST_OPEN_BAD_LOT})
            new_disp = DISP_BAD_LOT;
        else if (new_state inside {ST_DUMP_CLOSED_FILL, ST_DUMP_PASS})
            new_disp = DISP_DUMP_NEEDED;
        else
            new_disp = DISP_NORMAL;
    end

    assign result = '{state: new_state, disp: new_disp, done: new_done, count: new_count};

endmodule

@@ design/pack_gate_sequencer_core.sv @@
// ----------------------------------------------------------------------------
// pack_gate_sequencer_core - outlet valve sequencer of a seed packing machine
// tracks the valve through sixteen states from gate positions and events
// ----------------------------------------------------------------------------
// usage
//   in_ch  : valid/ready input words (kind, cut_gate_open, end_gate_open);
//            kind 0 is a periodic tick, 1..3 are forcing events
//   out_ch : valid/ready result words (valve_state, display_class, pack_done),
//            exactly one result word per input word, in order
//   cfg_we / cfg_wdata : writes empty_ticks; the user must write only while the block is idle, unchecked by the block
// path: the input register loads at the accepting edge, and the step logic fills
//   the result register from it once that register is free
// throughput: one word per cycle while out_ch is not held; the state and counter
//   update is a single pass of logic between the input and result registers
// reset: valve state closed empty, empty counter zero, empty_ticks 5,
//   both registers empty
// stall: while out_ch is held, the result register keeps its word and the
//   input register takes one more word, then in_ch.ready drops
// ----------------------------------------------------------------------------
module pack_gate_sequencer_core (
    input  logic                           clk,
    input  logic                           rst_n,
    pgs_in_if.sink                         in_ch,
    pgs_out_if.source                      out_ch,
    input  logic                           cfg_we,
    input  logic [pgs_pkg::CountWidth-1:0] cfg_wdata
);
    import pgs_pkg::*;

    // configuration
    logic [CountWidth-1:0] empty_ticks_reg;

    // architectural state
    valve_state_t          mode_reg;
    valve_state_t          mode_next;
    logic [CountWidth-1:0] count_reg;
    logic [CountWidth-1:0] count_next;

    // result register
    logic                  out_valid_reg;
    logic                  out_valid_next;
    step_t                 out_reg;

    // handshake between input register and step logic
    logic                  word_valid;
    in_word_t              word;
    logic                  take;
    step_t                 step_res;

    // the step fires when there is a word and the result slot is free
    assign take = word_valid && (!out_valid_reg || out_ch.ready);

    pgs_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .take       (take),
        .word_valid (word_valid),
        .word       (word)
    );

    pgs_step u_step (
        .mode        (mode_reg),
        .count       (count_reg),
        .empty_ticks (empty_ticks_reg),
        .word        (word),
        .result      (step_res)
    );

    always_comb
    begin
        mode_next      = take ? step_res.state : mode_reg;
        count_next     = take ? step_res.count : count_reg;
        out_valid_next = take || (out_valid_reg && !out_ch.ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            empty_ticks_reg <= EmptyTicksReset;
            mode_reg        <= ST_CLOSED_EMPTY;
            count_reg       <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                empty_ticks_reg <= cfg_wdata;
            end
            mode_reg      <= mode_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_reg <= step_res;
        end
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.valve_state   = out_reg.state;
    assign out_ch.display_class = out_reg.disp;
    assign out_ch.pack_done     = out_reg.done;

endmodule
